// ----- sv/rkfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rkfe_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;
  localparam int LEVEL_W     = 8;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_TICK  = 3'd0;
  localparam cmd_t CMD_WRITE = 3'd1;
  localparam cmd_t CMD_START = 3'd2;
  localparam cmd_t CMD_STOP  = 3'd3;
  localparam cmd_t CMD_COLOR = 3'd4;

  typedef logic [1:0] chan_t;

  localparam chan_t CH_RED   = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/rgb_keyframe_fade_engine.sv -----
// Write, stop, set color, reserved commands, a tick while stopped and a start with a zero repeat
// count go straight to the finish step, which registers the result; a tick or start that completes
// a frame reads the frame table, checks the duration and finishes; any other tick or start then
// interpolates the three channels in turn (per changed channel one multiply, eight divide steps, one add).
// One at a time: the next waits for the result to load, which waits while an earlier one is held.
// Reset (rst_n low, synchronous) clears position, cycles, elapsed time and all levels and sets
// the frame count to one; the frame table is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module rgb_keyframe_fade_engine #(
  parameter int MAX_FRAMES = 16,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [3:0] frame_index, [19:4] frame_duration, [27:20] red_in, [35:28] green_in,
  // [43:36] blue_in, [48:44] frames_used, [57:49] repeat_count, [63:58] zero.
  input  wire logic [rkfe_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] cmd.
  input  wire rkfe_pkg::cmd_t                     in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [7:0] red_level, [15:8] green_level, [23:16] blue_level, [24] active, [31:25] zero.
  output logic [rkfe_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  import rkfe_pkg::*;

  localparam int FPW    = $clog2(MAX_FRAMES);
  localparam int TOTW   = $clog2(MAX_FRAMES + 1);
  localparam int ENTW   = TIME_BITS + 3 * LEVEL_W;
  localparam int PRODW  = TIME_BITS + LEVEL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MUL,
    S_DIV,
    S_APL,
    S_FIN
  } state_t;

  state_t                 state_r;
  logic [FPW-1:0]         pos_r;
  logic [TOTW-1:0]        total_r;
  logic signed [8:0]      cyc_r;
  logic [TIME_BITS-1:0]   elapsed_r;
  logic [LEVEL_W-1:0]     start_r [3];
  logic [LEVEL_W-1:0]     cur_r [3];
  chan_t                  ch_r;
  logic                   neg_r;
  logic [TIME_BITS-1:0]   rem_r;
  logic [LEVEL_W-1:0]     lo_r;
  logic [LEVEL_W-1:0]     q_r;
  logic [2:0]             bit_cnt_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [3:0]             in_idx;
  logic [15:0]            in_dur;
  logic [LEVEL_W-1:0]     in_red;
  logic [LEVEL_W-1:0]     in_green;
  logic [LEVEL_W-1:0]     in_blue;
  logic [4:0]             in_used;
  logic signed [8:0]      in_rep;
  logic [4:0]             used_nz;
  logic [TOTW-1:0]        used_clamp;

  logic                   tbl_we;
  logic [ENTW-1:0]        tbl_wdata;
  logic [ENTW-1:0]        ent;
  logic [TIME_BITS-1:0]   ent_dur;
  logic [LEVEL_W-1:0]     ent_red;
  logic [LEVEL_W-1:0]     ent_green;
  logic [LEVEL_W-1:0]     ent_blue;

  logic [LEVEL_W-1:0]     ch_tgt;
  logic [LEVEL_W-1:0]     ch_start;
  logic                   ch_neg;
  logic [LEVEL_W-1:0]     ch_mag;
  logic [PRODW-1:0]       prod;
  logic [TIME_BITS:0]     rem_sh;
  logic [TIME_BITS:0]     rem_sub;
  logic                   q_bit;
  logic [LEVEL_W-1:0]     q_signed;
  logic [TOTW-1:0]        pos_inc;
  logic                   active;

  assign in_idx   = in_tdata[3:0];
  assign in_dur   = in_tdata[19:4];
  assign in_red   = in_tdata[27:20];
  assign in_green = in_tdata[35:28];
  assign in_blue  = in_tdata[43:36];
  assign in_used  = in_tdata[48:44];
  assign in_rep   = $signed(in_tdata[57:49]);

  assign used_nz    = (in_used == 5'd0) ? 5'd1 : in_used;
  assign used_clamp = (int'(used_nz) > MAX_FRAMES) ? TOTW'(MAX_FRAMES) : TOTW'(used_nz);

  assign in_tready = rst_n && (state_r == S_IDLE);

  assign tbl_we    = in_tvalid && in_tready && (in_tuser == CMD_WRITE) &&
                     (int'(in_idx) < MAX_FRAMES);
  assign tbl_wdata = {in_blue, in_green, in_red, TIME_BITS'(in_dur)};

  rkfe_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_FRAMES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (FPW'(in_idx)),
    .wr_data (tbl_wdata),
    .rd_en   (state_r == S_RD),
    .rd_addr (pos_r),
    .rd_data (ent)
  );

  assign ent_dur   = ent[TIME_BITS-1:0];
  assign ent_red   = ent[TIME_BITS +: LEVEL_W];
  assign ent_green = ent[TIME_BITS + LEVEL_W +: LEVEL_W];
  assign ent_blue  = ent[TIME_BITS + 2 * LEVEL_W +: LEVEL_W];

  always_comb begin
    case (ch_r)
      CH_RED:   ch_tgt = ent_red;
      CH_GREEN: ch_tgt = ent_green;
      CH_BLUE:  ch_tgt = ent_blue;
      default:  ch_tgt = ent_blue;
    endcase
  end

  assign ch_start = start_r[ch_r];
  assign ch_neg   = (ch_tgt < ch_start);
  assign ch_mag   = ch_neg ? (ch_start - ch_tgt) : (ch_tgt - ch_start);
  assign prod     = PRODW'(ch_mag) * PRODW'(elapsed_r);

  assign rem_sh   = {rem_r, lo_r[LEVEL_W-1]};
  assign rem_sub  = rem_sh - {1'b0, ent_dur};
  assign q_bit    = (rem_sh >= {1'b0, ent_dur});
  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;

  assign pos_inc  = TOTW'(pos_r) + 1'b1;
  assign active   = (cyc_r != 9'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      total_r     <= TOTW'(1);
      cyc_r       <= '0;
      elapsed_r   <= '0;
      ch_r        <= CH_RED;
      for (int c = 0; c < 3; c++) begin
        start_r[c] <= '0;
        cur_r[c]   <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            case (in_tuser)
              CMD_TICK: begin
                if (active) begin
                  if (elapsed_r != {TIME_BITS{1'b1}}) begin
                    elapsed_r <= elapsed_r + 1'b1;
                  end
                  state_r <= S_RD;
                end else begin
                  state_r <= S_FIN;
                end
              end
              CMD_START: begin
                total_r   <= used_clamp;
                pos_r     <= '0;
                elapsed_r <= '0;
                cyc_r     <= in_rep;
                state_r   <= (in_rep != 9'sd0) ? S_RD : S_FIN;
              end
              CMD_STOP: begin
                cyc_r   <= '0;
                state_r <= S_FIN;
              end
              CMD_COLOR: begin
                cur_r[CH_RED]   <= in_red;
                cur_r[CH_GREEN] <= in_green;
                cur_r[CH_BLUE]  <= in_blue;
                state_r         <= S_FIN;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (elapsed_r >= ent_dur) begin
            cur_r[CH_RED]     <= ent_red;
            cur_r[CH_GREEN]   <= ent_green;
            cur_r[CH_BLUE]    <= ent_blue;
            start_r[CH_RED]   <= ent_red;
            start_r[CH_GREEN] <= ent_green;
            start_r[CH_BLUE]  <= ent_blue;
            elapsed_r         <= '0;
            if (pos_inc >= total_r) begin
              pos_r <= '0;
              if (cyc_r > 9'sd0) begin
                cyc_r <= cyc_r - 9'sd1;
              end
            end else begin
              pos_r <= FPW'(pos_inc);
            end
            state_r <= S_FIN;
          end else begin
            ch_r    <= CH_RED;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (ch_tgt == ch_start) begin
            if (ch_r == CH_BLUE) begin
              state_r <= S_FIN;
            end else begin
              ch_r <= ch_r + 1'b1;
            end
          end else begin
            neg_r     <= ch_neg;
            rem_r     <= prod[PRODW-1:LEVEL_W];
            lo_r      <= prod[LEVEL_W-1:0];
            q_r       <= '0;
            bit_cnt_r <= 3'd7;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (q_bit) begin
            rem_r <= rem_sub[TIME_BITS-1:0];
          end else begin
            rem_r <= rem_sh[TIME_BITS-1:0];
          end
          lo_r <= {lo_r[LEVEL_W-2:0], 1'b0};
          q_r  <= {q_r[LEVEL_W-2:0], q_bit};
          if (bit_cnt_r == 3'd0) begin
            state_r <= S_APL;
          end else begin
            bit_cnt_r <= bit_cnt_r - 1'b1;
          end
        end
        S_APL: begin
          cur_r[ch_r] <= ch_start + q_signed;
          if (ch_r == CH_BLUE) begin
            state_r <= S_FIN;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'd0, active, cur_r[CH_BLUE], cur_r[CH_GREEN], cur_r[CH_RED]};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("engine accepted a transaction while still busy");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active |-> (TOTW'(pos_r) < total_r))
    else $error("frame position beyond frame count");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0) && (int'(total_r) <= MAX_FRAMES))
    else $error("frame count out of range");

  a_rem_below_dur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < ent_dur))
    else $error("divider remainder not below duration");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire

// ----- sv/rkfe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rkfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rkfe_pkg::*;

  localparam int   KEYFRAMES    = 16;
  localparam int   RANDOM_ITEMS = 400;
  localparam int   CALM_TAIL    = 60;
  localparam int   LONG_STALL   = 250;
  localparam int   STALL_AFTER  = 150;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   REPORT_MAX   = 10;
  localparam cmd_t CMD_RSVD_LO  = 3'd5;
  localparam cmd_t CMD_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic       active;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_state_t;

  typedef struct {
    cmd_t        op;
    logic [3:0]  slot;
    logic [15:0] dur;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [4:0]  used;
    logic [8:0]  rep;
  } fade_cmd_t;

  typedef struct {
    fade_cmd_t  cmd;
    bit         typed;
    led_state_t want;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  cmd_t        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  logic [15:0]       key_dur   [KEYFRAMES];
  logic [7:0]        key_color [KEYFRAMES][3];
  logic [KEYFRAMES-1:0] key_loaded;
  int                play_pos;
  int                play_len;
  logic signed [8:0] loops_left;
  logic [15:0]       ticks_in_frame;
  logic [7:0]        fade_from [3];
  logic [7:0]        level_now [3];

  led_state_t  expected_levels [$];
  script_row_t script [$];
  int          mismatches;
  int          items_sent;
  bit          idle_en;
  bit          stall_done;

  rgb_keyframe_fade_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic led_state_t levels(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic a);
    led_state_t s;
    s.red    = r;
    s.green  = g;
    s.blue   = b;
    s.active = a;
    return s;
  endfunction

  function automatic void advance_frame();
    int diff;
    int quo;
    if (loops_left == 0) return;
    if (ticks_in_frame >= key_dur[play_pos]) begin
      for (int c = 0; c < 3; c++) begin
        fade_from[c] = key_color[play_pos][c];
        level_now[c] = key_color[play_pos][c];
      end
      play_pos++;
      ticks_in_frame = '0;
      if (play_pos >= play_len) begin
        play_pos = 0;
        if (loops_left > 0) loops_left = loops_left - 9'sd1;
      end
      return;
    end
    for (int c = 0; c < 3; c++) begin
      diff = int'(key_color[play_pos][c]) - int'(fade_from[c]);
      if (diff != 0) begin
        quo = (diff * int'(ticks_in_frame)) / int'(key_dur[play_pos]);
        level_now[c] = 8'(int'(fade_from[c]) + quo);
      end
    end
  endfunction

  function automatic led_state_t run_command(fade_cmd_t t);
    case (t.op)
      CMD_TICK: begin
        if (loops_left != 0) begin
          if (ticks_in_frame != 16'hFFFF) ticks_in_frame++;
          advance_frame();
        end
      end
      CMD_WRITE: begin
        key_dur[t.slot]      = t.dur;
        key_color[t.slot][0] = t.red;
        key_color[t.slot][1] = t.green;
        key_color[t.slot][2] = t.blue;
        key_loaded[t.slot]   = 1'b1;
      end
      CMD_START: begin
        if (t.used == 0) play_len = 1;
        else if (int'(t.used) > KEYFRAMES) play_len = KEYFRAMES;
        else play_len = int'(t.used);
        play_pos       = 0;
        ticks_in_frame = '0;
        loops_left     = t.rep;
        advance_frame();
      end
      CMD_STOP: loops_left = '0;
      CMD_COLOR: begin
        level_now[0] = t.red;
        level_now[1] = t.green;
        level_now[2] = t.blue;
      end
      default: ;
    endcase
    return levels(level_now[0], level_now[1], level_now[2], loops_left != 0);
  endfunction

  function automatic void add_row(cmd_t op, logic [3:0] slot, logic [15:0] dur,
                                  logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [4:0] used, logic [8:0] rep,
                                  bit typed, led_state_t want);
    script_row_t row;
    row.cmd   = '{op, slot, dur, r, g, b, used, rep};
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < KEYFRAMES && key_loaded[n]) n++;
    return n;
  endfunction

  function automatic fade_cmd_t pick_command();
    fade_cmd_t t;
    int        roll;
    int        prefix;
    int        frames;
    prefix  = loaded_prefix();
    t.slot  = 4'($urandom);
    t.dur   = 16'($urandom);
    t.red   = 8'($urandom);
    t.green = 8'($urandom);
    t.blue  = 8'($urandom);
    t.used  = 5'($urandom);
    t.rep   = 9'($urandom);
    roll    = $urandom_range(0, 99);
    if (roll < 58) begin
      t.op = CMD_TICK;
    end else if (roll < 70) begin
      t.op = CMD_WRITE;
      if (prefix < KEYFRAMES && $urandom_range(0, 1) == 0) t.slot = 4'(prefix);
      roll = $urandom_range(0, 9);
      if (roll < 7) t.dur = 16'($urandom_range(0, 5));
      else if (roll < 9) t.dur = 16'($urandom_range(6, 40));
    end else if (roll < 80) begin
      t.op = CMD_START;
      if ($urandom_range(0, 3) == 0) frames = prefix;
      else frames = $urandom_range(1, prefix);
      t.used = 5'(frames);
      if (frames == 1 && $urandom_range(0, 1) == 0) t.used = 5'd0;
      if (frames == KEYFRAMES && $urandom_range(0, 1) == 0) t.used = 5'($urandom_range(16, 31));
      roll = $urandom_range(0, 19);
      if (roll < 5) t.rep = 9'd0;
      else if (roll < 13) t.rep = 9'($urandom_range(1, 3));
      else if (roll < 17) t.rep = 9'h1FF;
    end else if (roll < 84) begin
      t.op = CMD_STOP;
    end else if (roll < 92) begin
      t.op = CMD_COLOR;
    end else begin
      t.op = cmd_t'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    end
    return t;
  endfunction

  task automatic send_command(fade_cmd_t t, bit typed, led_state_t want);
    led_state_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = t.op;
    in_tdata  = {6'b0, t.rep, t.used, t.blue, t.green, t.red, t.dur, t.slot};
    do @(posedge clk); while (!in_tready);
    predicted = run_command(t);
    expected_levels.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** rgb_keyframe_fade_engine: FAILED **");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && items_sent >= STALL_AFTER) begin
        out_tready = 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        stall_done = 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    led_state_t got;
    led_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = led_state_t'(out_tdata[24:0]);
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected transaction on the result side: %h", out_tdata);
      end else begin
        want = expected_levels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected r=%h g=%h b=%h active=%b, got r=%h g=%h b=%h active=%b",
                     want.red, want.green, want.blue, want.active,
                     got.red, got.green, got.blue, got.active);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = CMD_TICK;
    idle_en        = 1'b1;
    mismatches     = 0;
    items_sent     = 0;
    key_loaded     = '0;
    play_pos       = 0;
    play_len       = 1;
    loops_left     = '0;
    ticks_in_frame = '0;
    for (int c = 0; c < 3; c++) begin
      fade_from[c] = '0;
      level_now[c] = '0;
    end

    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 1, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_RSVD_LO, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 1, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_RSVD_HI, 15, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 31, 9'h1FF, 1, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_COLOR,   0, 16'h0000, 8'hFF, 8'h00, 8'hFF, 0, 9'h000, 1, levels(8'hFF, 8'h00, 8'hFF, 0));
    add_row(CMD_WRITE,   0, 16'h0000, 8'h0A, 8'h14, 8'h1E, 0, 9'h000, 1, levels(8'hFF, 8'h00, 8'hFF, 0));
    add_row(CMD_WRITE,   1, 16'h0004, 8'hFA, 8'h00, 8'h82, 0, 9'h000, 1, levels(8'hFF, 8'h00, 8'hFF, 0));
    add_row(CMD_WRITE,   2, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 0, 9'h000, 1, levels(8'hFF, 8'h00, 8'hFF, 0));
    add_row(CMD_WRITE,   15, 16'h0003, 8'h01, 8'h02, 8'h03, 0, 9'h000, 1, levels(8'hFF, 8'h00, 8'hFF, 0));
    add_row(CMD_START,   0, 16'h0000, 8'h00, 8'h00, 8'h00, 3, 9'h000, 1, levels(8'hFF, 8'h00, 8'hFF, 0));
    add_row(CMD_START,   0, 16'h0000, 8'h00, 8'h00, 8'h00, 2, 9'h001, 1, levels(8'h0A, 8'h14, 8'h1E, 1));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_COLOR,   0, 16'h0000, 8'h80, 8'h80, 8'h80, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 1, levels(8'hFA, 8'h00, 8'h82, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 1, levels(8'hFA, 8'h00, 8'h82, 0));
    add_row(CMD_START,   0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h1FF, 1, levels(8'h0A, 8'h14, 8'h1E, 1));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 1, levels(8'h0A, 8'h14, 8'h1E, 1));
    add_row(CMD_STOP,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 1, levels(8'h0A, 8'h14, 8'h1E, 0));
    add_row(CMD_START,   0, 16'h0000, 8'h00, 8'h00, 8'h00, 3, 9'h0FF, 1, levels(8'h0A, 8'h14, 8'h1E, 1));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_TICK,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));
    add_row(CMD_STOP,    0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 9'h000, 0, levels(8'h00, 8'h00, 8'h00, 0));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) send_command(script[i].cmd, script[i].typed, script[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 50) % 4 != 3);
      send_command(pick_command(), 1'b0, levels(8'h00, 8'h00, 8'h00, 0));
    end
    in_tvalid = 1'b0;

    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("** rgb_keyframe_fade_engine: PASSED **");
    end else begin
      $display("** rgb_keyframe_fade_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rkfe_pkg.sv
sv/rkfe_ram.sv
sv/rgb_keyframe_fade_engine.sv
tb/testbench.sv
